[design/mcbar_pkg.sv]
// Shared types and constants for the multi-channel bridge converter reader.
// Used by the lane, the sequencer and the top level; no dependencies.
`default_nettype none
package mcbar_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 24;
   localparam int MAX_CH      = 8;
   localparam int OUT_CH      = 6;
   localparam int FIELD_BITS  = 24;
   localparam int LINE_BITS   = 6;
   localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);

   localparam logic [1:0] REG_TIMEOUT_MS  = 2'd0;
   localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
   localparam logic [1:0] REG_EXTRA       = 2'd2;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 152;

   typedef struct packed {
      logic [7:0] timeout_ms;
      logic [7:0] half_period_ticks;
      logic [1:0] extra_pulses;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic shift;
      logic capture;
   } lane_ctl_type;

   typedef struct packed {
      logic clock_level;
      logic busy;
      logic done;
      logic timed_out;
   } status_type;

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [SAMPLE_BITS-1:0] v);
      logic signed [31:0] w;
      w = 32'($signed(v));
      return w[FIELD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[design/multi_channel_bridge_adc_reader_top.sv]
// Multi-channel bridge converter reader: one response for each request, tick or start.
// The response for a request is registered in the output register, or in the skid register under stall.
// Throughput: one request per cycle while the skid register is empty; a skid register absorbs one response under stall.
// Reset: synchronous; sequencer idle, counters zero, registers 10/1/1, output empty.
// Held samples and shift registers reset to zero.
// Depends on mcbar_pkg, mcbar_seq and mcbar_lane.
`default_nettype none
module multi_channel_bridge_adc_reader_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [5:0] data_lines, [6] ms_strobe, [7] zero
   input  wire logic [mcbar_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] kind
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [0] clock_level, [1] busy_res, [2] done_res, [3] timed_out,
   // [27:4] sample_0 ... [147:124] sample_5, [151:148] zero
   output logic [mcbar_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [1:0]                            csr_index,
   input  wire logic [7:0]                            csr_data
);
   import mcbar_pkg::*;

   cfg_type                   cfg_ff;
   logic                      accept;
   lane_ctl_type              ctl;
   status_type                status;
   logic [MAX_CH-1:0]         lines_ext;
   logic [SAMPLE_BITS-1:0]    held [CHANNELS];
   logic [RSP_DATA_W-1:0]     result;
   logic                      out_valid_ff, skid_valid_ff;
   logic [RSP_DATA_W-1:0]     out_data_ff, skid_data_ff;
   logic                      out_stall;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign lines_ext  = MAX_CH'(req_tdata[LINE_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms        <= 8'd10;
         cfg_ff.half_period_ticks <= 8'd1;
         cfg_ff.extra_pulses      <= 2'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TIMEOUT_MS:  cfg_ff.timeout_ms        <= csr_data;
            REG_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_data;
            REG_EXTRA:       cfg_ff.extra_pulses      <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   mcbar_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .enable      (accept),
      .cfg         (cfg_ff),
      .kind        (req_tuser),
      .lines_clear (lines_ext[CHANNELS-1:0] == '0),
      .ms_strobe   (req_tdata[LINE_BITS]),
      .ctl         (ctl),
      .status      (status)
   );

   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      mcbar_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .enable   (accept),
         .ctl      (ctl),
         .data_bit (lines_ext[k]),
         .held     (held[k])
      );
   end

   always_comb begin
      result    = '0;
      result[0] = status.clock_level;
      result[1] = status.busy;
      result[2] = status.done;
      result[3] = status.timed_out;
      for (int k = 0; k < OUT_CH; k++) begin
         if (k < CHANNELS) begin
            result[4 + k*FIELD_BITS +: FIELD_BITS] = to_field(held[k % CHANNELS]);
         end
      end
   end

   assign out_stall = out_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_stall) begin
         if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (out_stall) begin
         if (accept) begin
            skid_data_ff <= result;
         end
      end else if (skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (accept) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while the output is empty");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1] && !rsp_tdata[3])
      else $error("completed read reported as still busy or timed out");

   a_timeout_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[1])
      else $error("timed out read still reported busy");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_stall |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled response changed");

endmodule
`default_nettype wire

[design/mcbar_lane.sv]
// One converter channel: shift register and held sample.
// Depends on mcbar_pkg for the lane control struct and sample width.
`default_nettype none
module mcbar_lane (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire mcbar_pkg::lane_ctl_type          ctl,
   input  wire logic                             data_bit,
   output logic [mcbar_pkg::SAMPLE_BITS-1:0]     held
);
   import mcbar_pkg::*;

   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;

   always_comb begin
      shift_in = shift_ff;
      held_in  = held_ff;
      if (ctl.clear) begin
         shift_in = '0;
      end else if (ctl.shift) begin
         shift_in = {shift_ff[SAMPLE_BITS-2:0], data_bit};
      end
      if (ctl.capture) begin
         held_in = shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         held_ff  <= '0;
      end else if (enable) begin
         shift_ff <= shift_in;
         held_ff  <= held_in;
      end
   end

   // show the sample as it stands after this transfer
   assign held = held_in;

endmodule
`default_nettype wire

[design/mcbar_seq.sv]
// Read sequencer: ready wait, timeout, clock pulse timing and bit counting.
// Depends on mcbar_pkg; drives the lane controls and per-item status.
`default_nettype none
module mcbar_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire mcbar_pkg::cfg_type           cfg,
   input  wire logic                         kind,
   input  wire logic                         lines_clear,
   input  wire logic                         ms_strobe,
   output mcbar_pkg::lane_ctl_type           ctl,
   output mcbar_pkg::status_type             status
);
   import mcbar_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic [7:0]             tick_ff, tick_in;
   logic [8:0]             ms_ff, ms_in;

   logic [7:0]             half_period;
   logic [1:0]             extra;
   logic [7:0]             tick_next;
   logic [8:0]             ms_next;
   logic [BIT_CNT_W-1:0]   bit_next;
   logic                   clk_lvl, done, tmo;

   always_comb begin
      half_period = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
      extra       = (cfg.extra_pulses == 2'd0) ? 2'd1 : cfg.extra_pulses;
      tick_next   = tick_ff + 8'((tick_ff != 8'hFF) ? 1 : 0);
      ms_next     = ms_ff + 9'((ms_ff != 9'h1FF) ? 1 : 0);
      bit_next    = bit_ff + BIT_CNT_W'(1);
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      tick_in     = tick_ff;
      ms_in       = ms_ff;
      ctl         = '0;
      clk_lvl     = 1'b0;
      done        = 1'b0;
      tmo         = 1'b0;
      if (kind == KIND_START) begin
         if (phase_ff == PH_IDLE) begin
            phase_in = PH_WAIT;
            ms_in    = '0;
         end
         clk_lvl = (phase_ff == PH_HIGH) || (phase_ff == PH_XHIGH);
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_WAIT: begin
               if (lines_clear) begin
                  phase_in  = PH_HIGH;
                  tick_in   = '0;
                  bit_in    = '0;
                  ctl.clear = 1'b1;
               end else if (ms_strobe) begin
                  ms_in = ms_next;
                  if (ms_next > {1'b0, cfg.timeout_ms}) begin
                     phase_in = PH_IDLE;
                     tmo      = 1'b1;
                  end
               end
            end
            PH_HIGH, PH_XHIGH: begin
               clk_lvl = 1'b1;
               tick_in = tick_next;
               if (tick_next >= half_period) begin
                  ctl.shift = (phase_ff == PH_HIGH);
                  phase_in  = (phase_ff == PH_HIGH) ? PH_LOW : PH_XLOW;
                  tick_in   = '0;
               end
            end
            PH_LOW, PH_XLOW: begin
               tick_in = tick_next;
               if (tick_next >= half_period) begin
                  tick_in = '0;
                  bit_in  = bit_next;
                  if (phase_ff == PH_LOW) begin
                     if (bit_next >= BIT_CNT_W'(SAMPLE_BITS)) begin
                        bit_in   = '0;
                        phase_in = PH_XHIGH;
                     end else begin
                        phase_in = PH_HIGH;
                     end
                  end else if (bit_next >= BIT_CNT_W'(extra)) begin
                     ctl.capture = 1'b1;
                     bit_in      = '0;
                     phase_in    = PH_IDLE;
                     done        = 1'b1;
                  end else begin
                     phase_in = PH_XHIGH;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (!enable) begin
         ctl = '0;
      end
      status.clock_level = clk_lvl;
      status.busy        = (phase_in != PH_IDLE);
      status.done        = done;
      status.timed_out   = tmo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= '0;
         tick_ff  <= '0;
         ms_ff    <= '0;
      end else if (enable) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         ms_ff    <= ms_in;
      end
   end

endmodule
`default_nettype wire

[sim/adc_reading_checker.sv]
// Scoreboard for the multi-channel bridge converter reader: predicts one reading per
// request transfer and compares it field by field with each response transfer.
// Depends on mcbar_pkg for port widths, register indexes, request kinds and cfg_type.
`default_nettype none
module adc_reading_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [mcbar_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                             req_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [mcbar_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [7:0]                       csr_data,
   output int                                    fail_count,
   output int                                    outstanding
);
   import mcbar_pkg::*;

   typedef enum logic [2:0] {
      RD_IDLE, RD_WAIT, RD_HIGH, RD_LOW, RD_XHIGH, RD_XLOW
   } rd_phase_type;

   typedef struct packed {
      logic                              clock_level;
      logic                              busy;
      logic                              done;
      logic                              timed_out;
      logic [OUT_CH-1:0][FIELD_BITS-1:0] sample;
   } reading_type;

   cfg_type                                cfg;
   rd_phase_type                           rd_phase;
   logic [BIT_CNT_W-1:0]                   pulse_count;
   logic [7:0]                             tick_count;
   logic [8:0]                             ms_count;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   shreg;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   held;
   reading_type                            readings_due[$];
   int                                     mismatches = 0;

   task automatic advance_reader(input logic kind, input logic [LINE_BITS-1:0] lines,
                                 input logic strobe, output reading_type r);
      logic [7:0]           hp;
      logic [BIT_CNT_W-1:0] xp;
      hp = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
      xp = (cfg.extra_pulses == 2'd0) ? BIT_CNT_W'(1) : BIT_CNT_W'(cfg.extra_pulses);
      r = '0;
      if (kind == KIND_START) begin
         if (rd_phase == RD_IDLE) begin
            rd_phase = RD_WAIT;
            ms_count = '0;
         end
         r.clock_level = (rd_phase == RD_HIGH) || (rd_phase == RD_XHIGH);
      end else begin
         case (rd_phase)
            RD_IDLE: begin
            end
            RD_WAIT: begin
               if (lines[CHANNELS-1:0] == '0) begin
                  rd_phase    = RD_HIGH;
                  tick_count  = '0;
                  pulse_count = '0;
                  shreg       = '0;
               end else if (strobe) begin
                  if (ms_count < 9'd511)
                     ms_count = ms_count + 9'd1;
                  if (ms_count > {1'b0, cfg.timeout_ms}) begin
                     rd_phase    = RD_IDLE;
                     r.timed_out = 1'b1;
                  end
               end
            end
            RD_HIGH, RD_XHIGH: begin
               r.clock_level = 1'b1;
               if (tick_count < 8'd255)
                  tick_count = tick_count + 8'd1;
               if (tick_count >= hp) begin
                  if (rd_phase == RD_HIGH) begin
                     for (int k = 0; k < CHANNELS; k++)
                        shreg[k] = {shreg[k][SAMPLE_BITS-2:0], lines[k]};
                     rd_phase = RD_LOW;
                  end else begin
                     rd_phase = RD_XLOW;
                  end
                  tick_count = '0;
               end
            end
            RD_LOW, RD_XLOW: begin
               if (tick_count < 8'd255)
                  tick_count = tick_count + 8'd1;
               if (tick_count >= hp) begin
                  tick_count  = '0;
                  pulse_count = pulse_count + 1'b1;
                  if (rd_phase == RD_LOW) begin
                     if (pulse_count >= SAMPLE_BITS) begin
                        pulse_count = '0;
                        rd_phase    = RD_XHIGH;
                     end else begin
                        rd_phase = RD_HIGH;
                     end
                  end else if (pulse_count >= xp) begin
                     held        = shreg;
                     pulse_count = '0;
                     rd_phase    = RD_IDLE;
                     r.done      = 1'b1;
                  end else begin
                     rd_phase = RD_XHIGH;
                  end
               end
            end
            default: rd_phase = RD_IDLE;
         endcase
      end
      r.busy   = (rd_phase != RD_IDLE);
      r.sample = held;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      reading_type fresh;
      reading_type want;
      reading_type got;
      if (reset) begin
         cfg.timeout_ms        = 8'd10;
         cfg.half_period_ticks = 8'd1;
         cfg.extra_pulses      = 2'd1;
         rd_phase    = RD_IDLE;
         pulse_count = '0;
         tick_count  = '0;
         ms_count    = '0;
         shreg       = '0;
         held        = '0;
         readings_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIMEOUT_MS:  cfg.timeout_ms = csr_data;
               REG_HALF_PERIOD: cfg.half_period_ticks = csr_data;
               REG_EXTRA:       cfg.extra_pulses = csr_data[1:0];
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.clock_level = rsp_tdata[0];
            got.busy        = rsp_tdata[1];
            got.done        = rsp_tdata[2];
            got.timed_out   = rsp_tdata[3];
            for (int k = 0; k < OUT_CH; k++)
               got.sample[k] = rsp_tdata[4 + FIELD_BITS*k +: FIELD_BITS];
            if (readings_due.size() == 0) begin
               $display("%0t: response with nothing pending, expected none actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = readings_due.pop_front();
               compare_field("clock_level", want.clock_level, got.clock_level);
               compare_field("busy_res", want.busy, got.busy);
               compare_field("done_res", want.done, got.done);
               compare_field("timed_out", want.timed_out, got.timed_out);
               for (int k = 0; k < OUT_CH; k++)
                  compare_field($sformatf("sample_%0d", k), want.sample[k], got.sample[k]);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_reader(req_tuser, req_tdata[LINE_BITS-1:0], req_tdata[LINE_BITS], fresh);
            readings_due.push_back(fresh);
         end
      end
      fail_count  <= mismatches;
      outstanding <= readings_due.size();
   end

endmodule
`default_nettype wire

[sim/tb_multi_channel_bridge_adc_reader_top.sv]
// Testbench top for the multi-channel bridge converter reader: drives ticks, start
// requests and register writes with random stalls on both streams, then gives the verdict.
// Depends on mcbar_pkg, the reader top level and adc_reading_checker.
`default_nettype none
module tb_multi_channel_bridge_adc_reader_top;
   import mcbar_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [7:0]            csr_data;
   int                    fail_count;
   int                    outstanding;

   bit                    flood;
   int                    calm_left;
   int                    items_sent;
   int                    cur_hp;
   int                    cur_xp;

   multi_channel_bridge_adc_reader_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   adc_reading_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #6000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [LINE_BITS-1:0] line_pattern();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return LINE_BITS'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_item(input logic kind, input logic [LINE_BITS-1:0] lines,
                            input logic strobe);
      int gap;
      if (flood) begin
         gap = 0;
      end else if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(10, 40);
         gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {1'b0, strobe, lines};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // hold the request stream until every reading has come back
   task automatic drain_readings();
      req_tvalid = 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic run_read(input bit cut);
      int hp_eff;
      int xp_eff;
      int data_ticks;
      hp_eff = (cur_hp == 0) ? 1 : cur_hp;
      xp_eff = (cur_xp == 0) ? 1 : cur_xp;
      repeat ($urandom_range(0, 3))
         send_item(KIND_TICK, LINE_BITS'($urandom), 1'($urandom));
      send_item(KIND_START, LINE_BITS'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 10))
         send_item(KIND_TICK, LINE_BITS'($urandom_range(1, 63)), 1'($urandom));
      send_item(KIND_TICK, '0, 1'($urandom));
      data_ticks = 2 * hp_eff * (SAMPLE_BITS + xp_eff) + $urandom_range(0, 3);
      if (cut)
         data_ticks = $urandom_range(1, data_ticks);
      repeat (data_ticks) begin
         if ($urandom_range(0, 31) == 0)
            send_item(KIND_START, LINE_BITS'($urandom), 1'($urandom));
         send_item(KIND_TICK, line_pattern(), 1'($urandom));
      end
   endtask

   initial begin : rsp_drain
      int gap;
      int taken;
      int calm;
      bit flooded;
      rsp_tready = 1'b0;
      flood      = 1'b0;
      taken      = 0;
      calm       = 0;
      flooded    = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!flooded && taken >= 250 && req_tvalid) begin
            // stall the result side long enough for the input to back up
            flooded    = 1'b1;
            flood      = 1'b1;
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            flood = 1'b0;
         end else begin
            if (calm > 0) begin
               gap = 0;
               calm--;
            end else begin
               if ($urandom_range(0, 15) == 0)
                  calm = $urandom_range(10, 40);
               gap = $urandom_range(0, 18);
            end
            if (gap > 0) begin
               rsp_tready = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      int phase_no;
      int reads;
      bit wrote;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_TICK;
      csr_valid  = 1'b0;
      csr_index  = REG_TIMEOUT_MS;
      csr_data   = '0;
      calm_left  = 0;
      items_sent = 0;
      cur_hp     = 1;
      cur_xp     = 1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      write_reg(REG_TIMEOUT_MS, 8'd1);
      send_item(KIND_TICK, 6'd0, 1'b0);
      send_item(KIND_TICK, 6'd63, 1'b1);
      send_item(KIND_START, 6'd63, 1'b1);
      send_item(KIND_TICK, 6'd63, 1'b1);
      send_item(KIND_START, 6'd0, 1'b0);
      send_item(KIND_TICK, 6'd1, 1'b0);
      send_item(KIND_TICK, 6'd32, 1'b1);
      send_item(KIND_TICK, 6'd0, 1'b1);
      send_item(KIND_START, 6'd21, 1'b0);
      send_item(KIND_TICK, 6'd0, 1'b1);
      send_item(KIND_TICK, 6'd63, 1'b0);
      send_item(KIND_TICK, 6'd0, 1'b0);
      send_item(KIND_START, 6'd42, 1'b1);
      send_item(KIND_TICK, 6'd42, 1'b1);
      send_item(KIND_TICK, 6'd21, 1'b0);
      send_item(KIND_TICK, 6'd63, 1'b1);
      drain_readings();

      phase_no = 0;
      while (items_sent < 900 || phase_no < 7) begin
         case (phase_no)
            2: begin
               cur_hp = 255;
               write_reg(REG_HALF_PERIOD, 8'd255);
               cur_xp = 3;
               write_reg(REG_EXTRA, 8'd3);
               send_item(KIND_START, LINE_BITS'($urandom), 1'b0);
               send_item(KIND_TICK, '0, 1'b0);
               repeat (270)
                  send_item(KIND_TICK, line_pattern(), 1'($urandom));
            end
            3: begin
               // shrink the half period while a long phase is partly counted
               cur_hp = 1;
               write_reg(REG_HALF_PERIOD, 8'd1);
               repeat (2 * (SAMPLE_BITS + 3) + 4)
                  send_item(KIND_TICK, line_pattern(), 1'($urandom));
            end
            5: begin
               write_reg(REG_TIMEOUT_MS, 8'd255);
               send_item(KIND_START, LINE_BITS'($urandom), 1'($urandom));
               repeat (256)
                  send_item(KIND_TICK, LINE_BITS'($urandom_range(1, 63)), 1'b1);
               send_item(KIND_TICK, LINE_BITS'($urandom), 1'($urandom));
            end
            default: begin
               wrote = 1'b0;
               if ($urandom_range(0, 1)) begin
                  case ($urandom_range(0, 9))
                     0, 1:    write_reg(REG_TIMEOUT_MS, 8'd0);
                     2:       write_reg(REG_TIMEOUT_MS, 8'd255);
                     3:       write_reg(REG_TIMEOUT_MS, 8'($urandom));
                     default: write_reg(REG_TIMEOUT_MS, 8'($urandom_range(1, 6)));
                  endcase
                  wrote = 1'b1;
               end
               if ($urandom_range(0, 1)) begin
                  cur_xp = $urandom_range(0, 3);
                  write_reg(REG_EXTRA, {6'($urandom), 2'(cur_xp)});
                  wrote = 1'b1;
               end
               if (!wrote || $urandom_range(0, 1)) begin
                  case ($urandom_range(0, 9))
                     0:             cur_hp = 0;
                     1, 2, 3, 4, 5: cur_hp = 1;
                     default:       cur_hp = $urandom_range(2, 3);
                  endcase
                  write_reg(REG_HALF_PERIOD, 8'(cur_hp));
               end
               if (phase_no % 7 == 4)
                  write_reg(REG_UNUSED, 8'($urandom));
               reads = 1;
               for (int n = 0; n < reads; n++)
                  run_read(n == reads - 1 && phase_no >= 6 && $urandom_range(0, 3) == 0);
            end
         endcase
         drain_readings();
         phase_no++;
      end

      repeat (4) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
